@@ rtl/pcpfs_pkg.sv @@
// Package for the point charge potential and field summation unit.
// Holds the field widths, the queue entry type and the engine state type.
// Used by every module in rtl.
package pcpfs_pkg;

	localparam int CoordW = 32;
	localparam int AccW = 64;
	localparam int QueueDepthDefault = 2;

	typedef struct packed {
		logic signed [CoordW:0] rx;
		logic signed [CoordW:0] ry;
		logic signed [CoordW:0] rz;
		logic signed [CoordW-1:0] w;
		logic singular;
		logic last;
	} item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQ, ST_SQRT, ST_D2, ST_D3, ST_D3H, ST_PDIV, ST_PACC,
		ST_FMUL, ST_FDIV, ST_FACC, ST_OUT
	} eng_state_t;

	typedef enum logic [1:0] {
		REG_PROBE_X = 2'd0,
		REG_PROBE_Y = 2'd1,
		REG_PROBE_Z = 2'd2
	} reg_idx_t;

	// Signed saturating add of a signed 64-bit acc and a sign/magnitude term
	function automatic logic [AccW-1:0] sat_add(input logic [AccW-1:0] acc,
			input logic neg, input logic [AccW-1:0] mag);
		logic [AccW-1:0] u;
		logic [AccW:0] t;
		u = acc ^ {1'b1, {(AccW-1){1'b0}}};
		if (neg) begin
			t = {1'b0, u} - {1'b0, mag};
			u = t[AccW] ? '0 : t[AccW-1:0];
		end else begin
			t = {1'b0, u} + {1'b0, mag};
			u = t[AccW] ? '1 : t[AccW-1:0];
		end
		return u ^ {1'b1, {(AccW-1){1'b0}}};
	endfunction

endpackage

@@ rtl/point_charge_potential_field_sum_unit.sv @@
// Channel   | Dir | Contents
// s_axis    | in  | tdata: point_x, point_y, point_z, point_weight; tlast: last_point
// m_axis    | out | tdata: potential, field_x, field_y, field_z; tuser: singular_seen
// cfg       | in  | index 0..2 = probe_x/y/z, 32-bit data
// A point's time in the engine is set by the bit-serial divider
// (128 steps, run once for the potential and once per axis, with setup and
// accumulate around each run) and the 34-step square root; a point on
// the probe skips both. A last point with an untaken result waits.
// Asynchronous active-low reset clears accumulators, probe and handshakes.
// The front end and queue keep accepting while the engine or output stall, until the queue is full.
module point_charge_potential_field_sum_unit import pcpfs_pkg::*; #(
	parameter int QueueDepth = QueueDepthDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [127:0] s_axis_tdata, // point_x, point_y, point_z, point_weight
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [255:0] m_axis_tdata, // potential, field_x, field_y, field_z
	output logic m_axis_tuser, // singular_seen
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data
);
	logic [CoordW-1:0] probe_x_q, probe_y_q, probe_z_q;
	logic f_valid, f_ready, e_valid, e_ready;
	item_t f_item, e_item;
	logic [4*AccW:0] res;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_x_q <= '0; probe_y_q <= '0; probe_z_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PROBE_X: probe_x_q <= cfg_data;
				REG_PROBE_Y: probe_y_q <= cfg_data;
				REG_PROBE_Z: probe_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pcpfs_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.px(s_axis_tdata[31:0]), .py(s_axis_tdata[63:32]),
		.pz(s_axis_tdata[95:64]), .pw(s_axis_tdata[127:96]),
		.plast(s_axis_tlast),
		.probe_x(probe_x_q), .probe_y(probe_y_q), .probe_z(probe_z_q),
		.out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
	);

	pcpfs_queue #(.Depth(QueueDepth)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
		.rd_valid(e_valid), .rd_ready(e_ready), .rd_item(e_item)
	);

	pcpfs_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.in_valid(e_valid), .in_ready(e_ready), .in_item(e_item),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res)
	);

	assign m_axis_tdata = res[4*AccW-1:0];
	assign m_axis_tuser = res[4*AccW];
endmodule

@@ rtl/pcpfs_front.sv @@
// Front end: takes input transactions, forms R = point - probe and the
// singular mark. Depends on pcpfs_pkg.
module pcpfs_front import pcpfs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [CoordW-1:0] px,
	input  logic [CoordW-1:0] py,
	input  logic [CoordW-1:0] pz,
	input  logic [CoordW-1:0] pw,
	input  logic plast,
	input  logic [CoordW-1:0] probe_x,
	input  logic [CoordW-1:0] probe_y,
	input  logic [CoordW-1:0] probe_z,
	output logic out_valid,
	input  logic out_ready,
	output item_t out_item
);
	logic valid_q;
	item_t item_q;
	item_t nxt;

	always_comb begin
		nxt.rx = {px[CoordW-1], px} - {probe_x[CoordW-1], probe_x};
		nxt.ry = {py[CoordW-1], py} - {probe_y[CoordW-1], probe_y};
		nxt.rz = {pz[CoordW-1], pz} - {probe_z[CoordW-1], probe_z};
		nxt.w = pw;
		nxt.last = plast;
		nxt.singular = (px == probe_x) && (py == probe_y) && (pz == probe_z);
	end

	assign in_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= nxt;
		end
	end
endmodule

@@ rtl/pcpfs_queue.sv @@
// Short FIFO between front end and engine.
// Depends on pcpfs_pkg for item_t.
module pcpfs_queue import pcpfs_pkg::*; #(
	parameter int Depth = QueueDepthDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  item_t wr_item,
	output logic rd_valid,
	input  logic rd_ready,
	output item_t rd_item
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	item_t mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != Depth[AW:0];
	assign rd_valid = cnt_q != '0;
	assign rd_item = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + {{AW{1'b0}}, wr} - {{AW{1'b0}}, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_item;
		end
	end
endmodule

@@ rtl/pcpfs_engine.sv @@
// Back end: square root, shared restoring divider, saturating accumulators
// and the result register. Depends on pcpfs_pkg.
module pcpfs_engine import pcpfs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  item_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output logic [4*AccW:0] out_data
);
	eng_state_t st_q, st_d;
	item_t it_q;
	logic [65:0] s_q;
	logic [33:0] d_q;
	logic [67:0] d2_q;
	logic [101:0] d3_q;
	logic [127:0] num_q, rem_q;
	logic [101:0] den_q;
	logic [63:0] q_q;
	logic [6:0] cnt_q;
	logic [1:0] ax_q, sq_idx;
	logic [AccW-1:0] pot_q, fx_q, fy_q, fz_q;
	logic sing_q;
	logic ovf_q;
	logic [AccW-1:0] r_pot_q, r_fx_q, r_fy_q, r_fz_q;
	logic r_sing_q, r_valid_q;
	logic [32:0] mag_sel;
	logic [31:0] wmag;
	logic [63:0] prod;
	logic [33:0] trial;
	logic [67:0] trial_sq;
	logic [128:0] rem_sh;
	logic [128:0] rem_sub;
	logic neg_sel, r_neg, fterm_neg;
	logic [AccW-1:0] qsat;
	logic res_load;

	assign wmag = it_q.w[31] ? 32'(-it_q.w) : 32'(it_q.w);
	always_comb begin
		unique case (sq_idx)
			2'd0: begin
				mag_sel = it_q.rx[32] ? -it_q.rx : it_q.rx;
				r_neg = it_q.rx[32];
			end
			2'd1: begin
				mag_sel = it_q.ry[32] ? -it_q.ry : it_q.ry;
				r_neg = it_q.ry[32];
			end
			default: begin
				mag_sel = it_q.rz[32] ? -it_q.rz : it_q.rz;
				r_neg = it_q.rz[32];
			end
		endcase
	end
	assign sq_idx = ax_q;
	assign prod = 64'(mag_sel) * 64'(mag_sel);
	assign trial = d_q | (34'd1 << cnt_q[5:0]);
	assign trial_sq = 68'(trial) * 68'(trial);
	assign rem_sh = {rem_q, num_q[127]};
	assign rem_sub = rem_sh - {27'd0, den_q};
	assign qsat = ovf_q ? '1 : q_q;
	assign fterm_neg = !(it_q.w[31] != r_neg);
	assign neg_sel = (st_q == ST_PACC) ? !it_q.w[31] : fterm_neg;
	assign res_load = (st_q == ST_OUT) && it_q.last && (st_d == ST_IDLE);

	assign in_ready = (st_q == ST_IDLE);
	assign out_valid = r_valid_q;
	assign out_data = {r_sing_q, r_fz_q, r_fy_q, r_fx_q, r_pot_q};

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (in_valid) st_d = in_item.singular ? ST_OUT : ST_SQ;
			ST_SQ: if (ax_q == 2'd2) st_d = ST_SQRT;
			ST_SQRT: if (cnt_q == 7'd0) st_d = ST_D2;
			ST_D2: st_d = ST_D3;
			ST_D3: st_d = ST_D3H;
			ST_D3H: st_d = ST_PDIV;
			ST_PDIV: if (cnt_q == 7'd0) st_d = ST_PACC;
			ST_PACC: st_d = ST_FMUL;
			ST_FMUL: st_d = ST_FDIV;
			ST_FDIV: if (cnt_q == 7'd0) st_d = ST_FACC;
			ST_FACC: st_d = (ax_q == 2'd2) ? ST_OUT : ST_FMUL;
			ST_OUT: if (!it_q.last || !r_valid_q || out_ready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			pot_q <= '0; fx_q <= '0; fy_q <= '0; fz_q <= '0;
			sing_q <= 1'b0;
			r_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (res_load) r_valid_q <= 1'b1;
			else if (r_valid_q && out_ready) r_valid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (in_valid && in_item.singular) sing_q <= 1'b1;
				ST_PACC: pot_q <= sat_add(pot_q, neg_sel, qsat);
				ST_FACC: begin
					unique case (ax_q)
						2'd0: fx_q <= sat_add(fx_q, neg_sel, qsat);
						2'd1: fy_q <= sat_add(fy_q, neg_sel, qsat);
						default: fz_q <= sat_add(fz_q, neg_sel, qsat);
					endcase
				end
				ST_OUT: if (res_load) begin
					pot_q <= '0; fx_q <= '0; fy_q <= '0; fz_q <= '0;
					sing_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				it_q <= in_item;
				ax_q <= 2'd0;
				s_q <= '0;
			end
			ST_SQ: begin
				s_q <= s_q + 66'(prod);
				ax_q <= ax_q + 2'd1;
				d_q <= '0;
				cnt_q <= 7'd33;
			end
			ST_SQRT: begin
				if ({2'b0, s_q} >= trial_sq) d_q <= trial;
				cnt_q <= cnt_q - 7'd1;
			end
			ST_D2: d2_q <= 68'(d_q) * 68'(d_q);
			ST_D3: begin
				// d^3 fits 102 bits; build it from two 34-by-34-bit partial products
				d3_q <= 102'(68'(d2_q[33:0]) * 68'(d_q));
				num_q <= {64'd0, wmag, 32'd0};
				den_q <= {68'd0, d_q};
				rem_q <= '0;
				q_q <= '0;
				ovf_q <= 1'b0;
				cnt_q <= 7'd127;
			end
			ST_D3H: d3_q <= d3_q + {68'(d2_q[67:34]) * 68'(d_q), 34'd0};
			ST_PDIV, ST_FDIV: begin
				num_q <= {num_q[126:0], 1'b0};
				if (!rem_sub[128]) begin
					rem_q <= rem_sub[127:0];
					ovf_q <= ovf_q | q_q[63];
					q_q <= {q_q[62:0], 1'b1};
				end else begin
					rem_q <= rem_sh[127:0];
					ovf_q <= ovf_q | q_q[63];
					q_q <= {q_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q - 7'd1;
			end
			ST_PACC: ax_q <= 2'd0;
			ST_FMUL: begin
				num_q <= {16'd0, 64'(wmag) * 64'(mag_sel[31:0] | 32'd0) +
					(mag_sel[32] ? {wmag, 32'd0} : 64'd0), 48'd0};
				den_q <= d3_q;
				rem_q <= '0;
				q_q <= '0;
				ovf_q <= 1'b0;
				cnt_q <= 7'd127;
			end
			ST_FACC: ax_q <= ax_q + 2'd1;
			ST_OUT: if (res_load) begin
				r_pot_q <= pot_q; r_fx_q <= fx_q; r_fy_q <= fy_q; r_fz_q <= fz_q;
				r_sing_q <= sing_q;
			end
			default: ;
		endcase
	end
endmodule
